// ----- hdl/lsps_pkg.sv -----
// shared types and constants for the lidar sector steering block
// no dependencies; imported by every other file of the block
package lsps_pkg;

  // sizing of the sector accumulators and the control law
  localparam int unsigned MAX_POINTS    = 8192;
  localparam int unsigned QUALITY_SHIFT = 2;
  localparam int unsigned OUTPUT_LIMIT  = 2000;
  localparam int unsigned MIN_SIDE      = 20;
  localparam int unsigned MIN_FRONT     = 10;

  // field and state widths
  localparam int ANG_W   = 16;
  localparam int DIST_W  = 18;
  localparam int QUAL_W  = 8;
  localparam int SUM_W   = 31;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int STEER_W = 12;
  localparam int ERR_W   = 28;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int TOT_W   = 48;
  localparam int MUL_W   = 42;
  localparam int ACC_W   = 43;
  localparam int DIV_CW  = $clog2(SUM_W);

  // register indexes, byte address is four times the index
  localparam logic [2:0] REG_GAIN_P      = 3'd0;
  localparam logic [2:0] REG_GAIN_I      = 3'd1;
  localparam logic [2:0] REG_GAIN_D      = 3'd2;
  localparam logic [2:0] REG_SETPOINT    = 3'd3;
  localparam logic [2:0] REG_BRAKE       = 3'd4;
  localparam logic [2:0] REG_SIDE_LOW    = 3'd5;
  localparam logic [2:0] REG_SIDE_HIGH   = 3'd6;
  localparam logic [2:0] REG_FRONT_HALF  = 3'd7;

  // register reset values
  localparam logic [15:0] RST_GAIN_P     = 16'd2560;
  localparam logic [15:0] RST_GAIN_I     = 16'd0;
  localparam logic [15:0] RST_GAIN_D     = 16'd5120;
  localparam logic [15:0] RST_SETPOINT   = 16'd600;
  localparam logic [15:0] RST_BRAKE      = 16'd300;
  localparam logic [15:0] RST_SIDE_LOW   = 16'd9102;
  localparam logic [15:0] RST_SIDE_HIGH  = 16'd16384;
  localparam logic [14:0] RST_FRONT_HALF = 15'd1820;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SUM_W-1:0]  quot;
  } div_rsp_t;

endpackage

// ----- hdl/lsps_if.sv -----
// point and result stream interfaces, valid/ready handshake
// depends on lsps_pkg for field widths
interface lsps_point_if import lsps_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ANG_W-1:0]  angle_q14;
  logic [DIST_W-1:0] distance_q2;
  logic [QUAL_W-1:0] quality;
  logic              last_point;

  modport source (output valid, angle_q14, distance_q2, quality, last_point, input ready);
  modport sink   (input valid, angle_q14, distance_q2, quality, last_point, output ready);
endinterface

interface lsps_result_if import lsps_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [SUM_W-1:0]          side_distance;
  logic signed [STEER_W-1:0] steering;
  logic                      brake;
  logic [CNT_W-1:0]          side_count;
  logic [CNT_W-1:0]          front_count;

  modport source (output valid, side_distance, steering, brake, side_count, front_count,
                  input ready);
  modport sink   (input valid, side_distance, steering, brake, side_count, front_count,
                  output ready);
endinterface

// ----- hdl/lsps_div.sv -----
// restoring divider for the side average, one quotient bit per cycle
// depends on lsps_pkg for the request and response structs
module lsps_div import lsps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q, dvs_q;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic              ge;

  // shift in the next dividend bit and try the subtract
  assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits replace the dividend bits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

// ----- hdl/lidar_sector_pd_steering_top.sv -----
// lidar sector accumulation with pid steering and front brake
// a point without last_point is taken without holding the input; a scan end holds the input
// through the side-average divider, then the pid terms one after another on one shared
// 17x25 multiplier, skipping both with 20 or fewer side points, plus any result stall
// no point is accepted while a scan end is worked on
// reset: asynchronous active low; sums, counts, pid state cleared, registers to defaults
module lidar_sector_pd_steering_top import lsps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  lsps_point_if.sink   pnt_i,
  lsps_result_if.source res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_ERR   = 4'd3;
  localparam logic [3:0] S_MLO   = 4'd4;
  localparam logic [3:0] S_MHI   = 4'd5;
  localparam logic [3:0] S_PSUM  = 4'd6;
  localparam logic [3:0] S_PACC  = 4'd7;
  localparam logic [3:0] S_SAT   = 4'd8;
  localparam logic [3:0] S_BMUL  = 4'd9;
  localparam logic [3:0] S_BCMP  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  localparam logic [SUM_W-1:0]    SUM_MAX   = {SUM_W{1'b1}};
  localparam logic signed [63:0]  TERM_MAX  = 64'sh100_0000_0000;
  localparam logic signed [63:0]  TERM_MIN  = -64'sh100_0000_0000;
  localparam logic signed [48:0]  TOT_MAX   = 49'sh7FFF_FFFF_FFFF;
  localparam logic signed [48:0]  TOT_MIN   = -49'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] STEER_LIM = ACC_W'(OUTPUT_LIMIT * 1024);
  localparam logic signed [STEER_W-1:0] STEER_MAX = STEER_W'(OUTPUT_LIMIT);
  localparam logic [STEER_W+1:0]  SLEW_MAX  = (STEER_W + 2)'(3 * OUTPUT_LIMIT);

  // configuration registers
  logic [15:0] gain_p_q, gain_i_q, gain_d_q, setpoint_q, brake_mm_q;
  logic [15:0] side_low_q, side_high_q;
  logic [14:0] front_half_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= RST_GAIN_P;
      gain_i_q     <= RST_GAIN_I;
      gain_d_q     <= RST_GAIN_D;
      setpoint_q   <= RST_SETPOINT;
      brake_mm_q   <= RST_BRAKE;
      side_low_q   <= RST_SIDE_LOW;
      side_high_q  <= RST_SIDE_HIGH;
      front_half_q <= RST_FRONT_HALF;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GAIN_P:     gain_p_q     <= pwdata[15:0];
        REG_GAIN_I:     gain_i_q     <= pwdata[15:0];
        REG_GAIN_D:     gain_d_q     <= pwdata[15:0];
        REG_SETPOINT:   setpoint_q   <= pwdata[15:0];
        REG_BRAKE:      brake_mm_q   <= pwdata[15:0];
        REG_SIDE_LOW:   side_low_q   <= pwdata[15:0];
        REG_SIDE_HIGH:  side_high_q  <= pwdata[15:0];
        REG_FRONT_HALF: front_half_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_GAIN_P:     prdata = {16'b0, gain_p_q};
      REG_GAIN_I:     prdata = {16'b0, gain_i_q};
      REG_GAIN_D:     prdata = {16'b0, gain_d_q};
      REG_SETPOINT:   prdata = {16'b0, setpoint_q};
      REG_BRAKE:      prdata = {16'b0, brake_mm_q};
      REG_SIDE_LOW:   prdata = {16'b0, side_low_q};
      REG_SIDE_HIGH:  prdata = {16'b0, side_high_q};
      REG_FRONT_HALF: prdata = {17'b0, front_half_q};
      default:        prdata = '0;
    endcase
  end

  // sequencer and pid state
  logic [3:0]                state_q;
  logic [1:0]                term_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [MUL_W-1:0]   lo_q, hi_q;
  logic signed [63:0]        prod_q;
  logic signed [ERR_W-1:0]   last_err_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [TOT_W-1:0]   total_q;
  logic signed [STEER_W-1:0] last_steer_q, steer_q;
  logic [SUM_W-1:0]          side_out_q;
  logic                      brake_q;

  // sector accumulators
  logic [SUM_W-1:0] side_sum_q, front_sum_q;
  logic [CNT_W-1:0] side_pts_q, front_pts_q;

  // output register
  logic                      res_valid_q;
  logic [SUM_W-1:0]          res_dist_q;
  logic signed [STEER_W-1:0] res_steer_q;
  logic                      res_brake_q;
  logic [CNT_W-1:0]          res_side_q, res_front_q;
  logic                      res_load;

  // point classification
  logic              pnt_acc, pt_ok, in_side, in_front, side_add, front_add, sums_clr;
  logic [SUM_W:0]    side_ext, front_ext;

  assign pnt_i.ready = (state_q == S_IDLE);
  assign pnt_acc     = pnt_i.valid & pnt_i.ready;
  assign pt_ok       = (pnt_i.quality >> QUALITY_SHIFT) != '0;
  assign in_side     = (pnt_i.angle_q14 >= side_low_q) && (pnt_i.angle_q14 <= side_high_q);
  assign in_front    = ({1'b0, pnt_i.angle_q14} <= {2'b0, front_half_q}) ||
                       ({1'b0, pnt_i.angle_q14} >= (17'h10000 - {2'b0, front_half_q}));
  assign side_add    = pnt_acc & pt_ok & in_side & (side_pts_q < CNT_W'(MAX_POINTS));
  assign front_add   = pnt_acc & pt_ok & !in_side & in_front &
                       (front_pts_q < CNT_W'(MAX_POINTS));
  assign side_ext    = {1'b0, side_sum_q} + (SUM_W + 1)'(pnt_i.distance_q2);
  assign front_ext   = {1'b0, front_sum_q} + (SUM_W + 1)'(pnt_i.distance_q2);
  assign res_load    = (state_q == S_FIN) && (!res_valid_q || res_o.ready);
  assign sums_clr    = res_load;

  // saturating sector sums, cleared when the scan result is loaded into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_sum_q  <= '0;
      side_pts_q  <= '0;
      front_sum_q <= '0;
      front_pts_q <= '0;
    end else if (sums_clr) begin
      side_sum_q  <= '0;
      side_pts_q  <= '0;
      front_sum_q <= '0;
      front_pts_q <= '0;
    end else begin
      if (side_add) begin
        side_sum_q <= side_ext[SUM_W] ? SUM_MAX : side_ext[SUM_W-1:0];
        side_pts_q <= side_pts_q + 1'b1;
      end
      if (front_add) begin
        front_sum_q <= front_ext[SUM_W] ? SUM_MAX : front_ext[SUM_W-1:0];
        front_pts_q <= front_pts_q + 1'b1;
      end
    end
  end

  // side average divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.start    = (state_q == S_START) && (side_pts_q > CNT_W'(MIN_SIDE));
  assign div_req.dividend = side_sum_q;
  assign div_req.divisor  = side_pts_q;

  lsps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared multiplier operand selection
  logic [15:0]              mul_a;
  logic signed [24:0]       mul_b;
  logic signed [MUL_W-1:0]  mul_p;
  logic signed [TOT_W-1:0]  op48;
  logic [CNT_W-1:0]         fp_sel;

  assign fp_sel = (front_pts_q > CNT_W'(MIN_FRONT)) ? front_pts_q : CNT_W'(1);

  always_comb begin
    case (term_q)
      2'd0:    op48 = {{(TOT_W-ERR_W){last_err_q[ERR_W-1]}}, last_err_q};
      2'd1:    op48 = total_q;
      2'd2:    op48 = {{(TOT_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
      default: op48 = '0;
    endcase
  end

  always_comb begin
    if (state_q == S_BMUL) begin
      mul_a = brake_mm_q;
    end else begin
      case (term_q)
        2'd0:    mul_a = gain_p_q;
        2'd1:    mul_a = gain_i_q;
        2'd2:    mul_a = gain_d_q;
        default: mul_a = '0;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      S_MLO:   mul_b = $signed({1'b0, op48[23:0]});
      S_MHI:   mul_b = $signed({op48[TOT_W-1], op48[TOT_W-1:24]});
      S_BMUL:  mul_b = $signed({(25 - CNT_W)'(0), fp_sel});
      default: mul_b = '0;
    endcase
  end

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // error, derivative and saturating integral
  logic signed [31:0]        err_w;
  logic signed [ERR_W-1:0]   err_n;
  logic signed [48:0]        tot_sum;

  assign err_w   = $signed({14'b0, setpoint_q, 2'b00}) - $signed({1'b0, div_rsp.quot});
  assign err_n   = err_w[ERR_W-1:0];
  assign tot_sum = {total_q[TOT_W-1], total_q} + {{(49-ERR_W){err_n[ERR_W-1]}}, err_n};

  // term clamp to the product limit
  logic signed [MUL_W-1:0]   term_cl;

  always_comb begin
    if (prod_q > TERM_MAX)       term_cl = TERM_MAX[MUL_W-1:0];
    else if (prod_q < TERM_MIN)  term_cl = TERM_MIN[MUL_W-1:0];
    else                         term_cl = prod_q[MUL_W-1:0];
  end

  // output scaling with truncation toward zero, and the slew guard
  logic signed [ACC_W-1:0]   acc_adj;
  logic signed [STEER_W-1:0] steer_new;
  logic signed [STEER_W:0]   delta;
  logic [STEER_W:0]          delta_abs;

  assign acc_adj = acc_q + (acc_q[ACC_W-1] ? ACC_W'(1023) : ACC_W'(0));

  always_comb begin
    if (acc_q > STEER_LIM)        steer_new = STEER_MAX;
    else if (acc_q < -STEER_LIM)  steer_new = -STEER_MAX;
    else                          steer_new = acc_adj[STEER_W+9:10];
  end

  assign delta     = {steer_new[STEER_W-1], steer_new} - {last_steer_q[STEER_W-1], last_steer_q};
  assign delta_abs = delta[STEER_W] ? -delta : delta;

  // scan end sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      term_q       <= '0;
      last_err_q   <= '0;
      total_q      <= '0;
      last_steer_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (pnt_acc && pnt_i.last_point) state_q <= S_START;
        end
        S_START: begin
          term_q  <= '0;
          state_q <= (side_pts_q > CNT_W'(MIN_SIDE)) ? S_DIV : S_SAT;
        end
        S_DIV: begin
          if (div_rsp.done) state_q <= S_ERR;
        end
        S_ERR: begin
          last_err_q <= err_n;
          if (tot_sum > TOT_MAX)      total_q <= TOT_MAX[TOT_W-1:0];
          else if (tot_sum < TOT_MIN) total_q <= TOT_MIN[TOT_W-1:0];
          else                        total_q <= tot_sum[TOT_W-1:0];
          state_q <= S_MLO;
        end
        S_MLO:  state_q <= S_MHI;
        S_MHI:  state_q <= S_PSUM;
        S_PSUM: state_q <= S_PACC;
        S_PACC: begin
          if (term_q == 2'd2) begin
            state_q <= S_SAT;
          end else begin
            term_q  <= term_q + 1'b1;
            state_q <= S_MLO;
          end
        end
        S_SAT: begin
          if (delta_abs <= SLEW_MAX[STEER_W:0]) last_steer_q <= steer_new;
          state_q <= S_BMUL;
        end
        S_BMUL: state_q <= S_BCMP;
        S_BCMP: state_q <= S_FIN;
        S_FIN: begin
          if (res_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_START: begin
        side_out_q <= side_sum_q;
        acc_q      <= '0;
      end
      S_ERR: begin
        side_out_q <= div_rsp.quot;
        diff_q     <= {err_n[ERR_W-1], err_n} - {last_err_q[ERR_W-1], last_err_q};
      end
      S_MLO:  lo_q <= mul_p;
      S_MHI:  hi_q <= mul_p;
      S_PSUM: prod_q <= ($signed({{(64-MUL_W){hi_q[MUL_W-1]}}, hi_q}) <<< 24) +
                        $signed({{(64-MUL_W){lo_q[MUL_W-1]}}, lo_q});
      S_PACC: acc_q <= acc_q + {term_cl[MUL_W-1], term_cl};
      S_SAT:  steer_q <= (delta_abs > SLEW_MAX[STEER_W:0]) ? last_steer_q : steer_new;
      S_BMUL: lo_q <= mul_p;
      S_BCMP: brake_q <= (front_pts_q >= CNT_W'(MIN_FRONT)) &&
                         ({2'b0, front_sum_q} <= {lo_q[SUM_W-1:0], 2'b00});
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_dist_q  <= side_out_q;
      res_steer_q <= steer_q;
      res_brake_q <= brake_q;
      res_side_q  <= side_pts_q;
      res_front_q <= front_pts_q;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.side_distance = res_dist_q;
  assign res_o.steering      = res_steer_q;
  assign res_o.brake         = res_brake_q;
  assign res_o.side_count    = res_side_q;
  assign res_o.front_count   = res_front_q;

endmodule

// ----- hdl/lsps_checker.sv -----
// port-level checks for the lidar sector steering block, bound to the top level
// depends on lsps_pkg and lidar_sector_pd_steering_top
module lsps_checker import lsps_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [SUM_W-1:0]          side_distance,
  input logic signed [STEER_W-1:0] steering,
  input logic                      brake,
  input logic [CNT_W-1:0]          side_count,
  input logic [CNT_W-1:0]          front_count
);

  localparam logic signed [STEER_W-1:0] STEER_MAX = STEER_W'(OUTPUT_LIMIT);

  // a scan end holds off the next point
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("point taken right after a scan end");

  // steering stays inside the output limit
  a_steer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (steering <= STEER_MAX) && (steering >= -STEER_MAX))
    else $error("steering beyond limit");

  // too few side points give no steering
  a_few_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (side_count <= CNT_W'(MIN_SIDE)) |-> steering == '0)
    else $error("steering with too few side points");

  // brake needs enough front points
  a_brake_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && brake |-> front_count >= CNT_W'(MIN_FRONT))
    else $error("brake with too few front points");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid &&
      $stable({side_distance, steering, brake, side_count, front_count}))
    else $error("stalled result changed");

endmodule

bind lidar_sector_pd_steering_top lsps_checker u_lsps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (pnt_i.valid),
  .in_ready      (pnt_i.ready),
  .in_last       (pnt_i.last_point),
  .out_valid     (res_o.valid),
  .out_ready     (res_o.ready),
  .side_distance (res_o.side_distance),
  .steering      (res_o.steering),
  .brake         (res_o.brake),
  .side_count    (res_o.side_count),
  .front_count   (res_o.front_count)
);

// ----- tb/testbench.sv -----
// self-checking testbench for lidar_sector_pd_steering_top: point requests in, scan results out
// depends on lsps_pkg and the point/result interfaces; a scoreboard class predicts every scan end
import lsps_pkg::*;

localparam int     SIDE_SECTOR  = 0;
localparam int     FRONT_SECTOR = 1;
localparam int     FULL_TURN    = 65536;
localparam int     DIST_MAX     = 262143;
localparam longint SUM_LIMIT    = 64'h0000_0000_7FFF_FFFF;
localparam longint TOTAL_LIMIT  = 64'h0000_7FFF_FFFF_FFFF;
localparam longint TERM_LIMIT   = 64'h0000_0100_0000_0000;
localparam longint STEER_LIMIT  = OUTPUT_LIMIT;
localparam int     MAX_REPORTS  = 10;

typedef struct {
  logic [ANG_W-1:0]  angle;
  logic [DIST_W-1:0] distance;
  logic [QUAL_W-1:0] quality;
  logic              last_point;
} lidar_point_t;

typedef struct {
  logic [SUM_W-1:0]          side_distance;
  logic signed [STEER_W-1:0] steering;
  logic                      brake;
  logic [CNT_W-1:0]          side_count;
  logic [CNT_W-1:0]          front_count;
} scan_result_t;

typedef struct {
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [15:0] setpoint;
  logic [15:0] brake;
  logic [15:0] side_low;
  logic [15:0] side_high;
  logic [15:0] front_half;
} reg_set_t;

// sector sums, pid state and the queue of scan results still to come
class scan_scoreboard;
  logic [15:0] gain_p, gain_i, gain_d, setpoint_mm, brake_mm, side_low, side_high;
  logic [14:0] front_half;
  longint      sector_sum[2];
  longint      sector_points[2];
  longint      held_err;
  longint      error_total;
  longint      prev_steer;
  scan_result_t expected_scans[$];
  int unsigned failures;

  function new();
    gain_p = RST_GAIN_P;
    gain_i = RST_GAIN_I;
    gain_d = RST_GAIN_D;
    setpoint_mm = RST_SETPOINT;
    brake_mm = RST_BRAKE;
    side_low = RST_SIDE_LOW;
    side_high = RST_SIDE_HIGH;
    front_half = RST_FRONT_HALF;
    sector_sum = '{0, 0};
    sector_points = '{0, 0};
    held_err = 0;
    error_total = 0;
    prev_steer = 0;
    failures = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] word);
    case (idx)
      REG_GAIN_P:     gain_p = word[15:0];
      REG_GAIN_I:     gain_i = word[15:0];
      REG_GAIN_D:     gain_d = word[15:0];
      REG_SETPOINT:   setpoint_mm = word[15:0];
      REG_BRAKE:      brake_mm = word[15:0];
      REG_SIDE_LOW:   side_low = word[15:0];
      REG_SIDE_HIGH:  side_high = word[15:0];
      REG_FRONT_HALF: front_half = word[14:0];
      default: ;
    endcase
  endfunction

  function longint saturate(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // a full sector drops the point, the sum saturates
  function void add_to_sector(int s, longint d);
    if (sector_points[s] >= MAX_POINTS) return;
    sector_sum[s] = (sector_sum[s] + d > SUM_LIMIT) ? SUM_LIMIT : sector_sum[s] + d;
    sector_points[s]++;
  endfunction

  function bit waiting();
    return expected_scans.size() != 0;
  endfunction

  // accumulate one accepted point request, predict the result on the last one
  function void note_point(lidar_point_t p);
    longint avg, err, diff, acc, side_out, steer, delta;
    bit brake;
    scan_result_t r;
    if ((p.quality >> QUALITY_SHIFT) != 0) begin
      if (p.angle >= side_low && p.angle <= side_high) begin
        add_to_sector(SIDE_SECTOR, p.distance);
      end else if (p.angle <= front_half || int'(p.angle) >= FULL_TURN - int'(front_half)) begin
        add_to_sector(FRONT_SECTOR, p.distance);
      end
    end
    if (!p.last_point) return;

    // pid step only with enough side points
    side_out = sector_sum[SIDE_SECTOR];
    steer = 0;
    if (sector_points[SIDE_SECTOR] > MIN_SIDE) begin
      avg = sector_sum[SIDE_SECTOR] / sector_points[SIDE_SECTOR];
      err = longint'(setpoint_mm) * 4 - avg;
      diff = err - held_err;
      side_out = avg;
      error_total = saturate(error_total + err, TOTAL_LIMIT);
      held_err = err;
      acc = saturate(longint'(gain_p) * err, TERM_LIMIT)
          + saturate(longint'(gain_i) * error_total, TERM_LIMIT)
          + saturate(longint'(gain_d) * diff, TERM_LIMIT);
      if (acc > STEER_LIMIT * 1024) steer = STEER_LIMIT;
      else if (acc < -STEER_LIMIT * 1024) steer = -STEER_LIMIT;
      else steer = acc / 1024;
    end

    // slew guard
    delta = steer - prev_steer;
    if (delta < 0) delta = -delta;
    if (delta > 3 * STEER_LIMIT) steer = prev_steer;
    else prev_steer = steer;

    // brake: exact average above ten points, raw sum at exactly ten
    brake = 1'b0;
    if (sector_points[FRONT_SECTOR] > MIN_FRONT) begin
      brake = sector_sum[FRONT_SECTOR] <=
              longint'(brake_mm) * 4 * sector_points[FRONT_SECTOR];
    end else if (sector_points[FRONT_SECTOR] == MIN_FRONT) begin
      brake = sector_sum[FRONT_SECTOR] <= longint'(brake_mm) * 4;
    end

    r.side_distance = side_out[SUM_W-1:0];
    r.steering = steer[STEER_W-1:0];
    r.brake = brake;
    r.side_count = sector_points[SIDE_SECTOR][CNT_W-1:0];
    r.front_count = sector_points[FRONT_SECTOR][CNT_W-1:0];
    expected_scans.push_back(r);
    sector_sum = '{0, 0};
    sector_points = '{0, 0};
  endfunction

  // compare one accepted result with the oldest prediction
  function void check_result(scan_result_t got);
    scan_result_t want;
    if (expected_scans.size() == 0) begin
      if (failures < MAX_REPORTS) begin
        $display("unexpected result: side %0d steer %0d brake %0d counts %0d/%0d",
                 got.side_distance, got.steering, got.brake, got.side_count, got.front_count);
      end
      failures++;
      return;
    end
    want = expected_scans.pop_front();
    if (got.side_distance !== want.side_distance || got.steering !== want.steering ||
        got.brake !== want.brake || got.side_count !== want.side_count ||
        got.front_count !== want.front_count) begin
      if (failures < MAX_REPORTS) begin
        $display("result mismatch: expected side %0d steer %0d brake %0d counts %0d/%0d",
                 want.side_distance, want.steering, want.brake, want.side_count,
                 want.front_count);
        $display("                 actual   side %0d steer %0d brake %0d counts %0d/%0d",
                 got.side_distance, got.steering, got.brake, got.side_count, got.front_count);
      end
      failures++;
    end
  endfunction
endclass

module testbench;
  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_PCT      = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 64;
  localparam int PHASE_POINTS  = 300;
  localparam int RANDOM_POINTS = 1850;
  localparam int FILL_POINTS   = 40;
  localparam int CYCLE_LIMIT   = 1000000;

  logic        clk;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          quiet;
  bit          hold_req;
  int          random_points;
  int          cycle_count;

  scan_scoreboard sb;

  lsps_point_if  pnt ();
  lsps_result_if res ();

  lidar_sector_pd_steering_top u_top (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .pnt_i   (pnt),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side ready, random idling and one long hold-off
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      res.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor both handshakes; results are checked before a new request is noted
  always @(posedge clk) begin
    scan_result_t got;
    lidar_point_t seen;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        got.side_distance = res.side_distance;
        got.steering = res.steering;
        got.brake = res.brake;
        got.side_count = res.side_count;
        got.front_count = res.front_count;
        sb.check_result(got);
      end
      if (pnt.valid && pnt.ready) begin
        seen.angle = pnt.angle_q14;
        seen.distance = pnt.distance_q2;
        seen.quality = pnt.quality;
        seen.last_point = pnt.last_point;
        sb.note_point(seen);
      end
    end
  end

  // offer one point request and hold it until accepted
  task automatic send_point(input lidar_point_t p);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      pnt.valid <= 1'b0;
      @(posedge clk);
    end
    pnt.valid <= 1'b1;
    pnt.angle_q14 <= p.angle;
    pnt.distance_q2 <= p.distance;
    pnt.quality <= p.quality;
    pnt.last_point <= p.last_point;
    do @(posedge clk); while (!pnt.ready);
  endtask

  task automatic send_fields(input logic [ANG_W-1:0] ang, input logic [DIST_W-1:0] range_q2,
                             input logic [QUAL_W-1:0] qual, input logic last);
    lidar_point_t p;
    p.angle = ang;
    p.distance = range_q2;
    p.quality = qual;
    p.last_point = last;
    send_point(p);
  endtask

  // one apb write, setup then access; psel stays up for a following write
  task automatic write_one(input logic [2:0] idx, input logic [15:0] val);
    logic [31:0] word;
    word = {16'($urandom), val};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, word);
  endtask

  // stop offering, wait for every predicted scan, then let the block settle
  task automatic finish_phase();
    pnt.valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one well-formed scan: chosen side/front/noise counts, interleaved at random
  task automatic send_random_scan();
    int n_side, n_front, n_noise, remaining, pick, side_mode, front_mode;
    longint center, front_cap, d;
    lidar_point_t p;
    if ($urandom_range(0, 99) < 15) begin
      n_side = $urandom_range(0, 3);
      n_front = $urandom_range(0, 3);
      n_noise = $urandom_range(0, 3);
    end else begin
      n_side = ($urandom_range(0, 4) == 0) ? $urandom_range(19, 22) : $urandom_range(21, 40);
      case ($urandom_range(0, 4))
        0:       n_front = $urandom_range(0, 3);
        1, 2:    n_front = $urandom_range(9, 11);
        default: n_front = $urandom_range(12, 20);
      endcase
      n_noise = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (n_side + n_front + n_noise == 0) n_noise = 1;
    remaining = n_side + n_front + n_noise;
    side_mode = $urandom_range(0, 2);
    front_mode = $urandom_range(0, 2);
    center = longint'(sb.setpoint_mm) * 4;
    if (center > DIST_MAX) center = DIST_MAX;
    front_cap = longint'(sb.brake_mm) * 4;
    if (front_cap > DIST_MAX) front_cap = DIST_MAX;
    if (front_mode == 2) front_cap = front_cap / 10;
    while (remaining > 0) begin
      pick = $urandom_range(0, remaining - 1);
      if (pick < n_side) begin
        n_side--;
        if (sb.side_low <= sb.side_high) p.angle = 16'($urandom_range(sb.side_high, sb.side_low));
        else p.angle = 16'($urandom);
        case (side_mode)
          0: d = $urandom_range(0, DIST_MAX);
          1: begin
            d = center + longint'($urandom_range(0, 4000)) - 2000;
            if (d < 0) d = 0;
            if (d > DIST_MAX) d = DIST_MAX;
          end
          default: d = $urandom_range(0, 255);
        endcase
        p.quality = 8'($urandom_range(4, 255));
      end else if (pick < n_side + n_front) begin
        n_front--;
        if ($urandom_range(0, 1) == 0) p.angle = 16'($urandom_range(0, sb.front_half));
        else p.angle = 16'(FULL_TURN - $urandom_range(0, sb.front_half));
        d = (front_mode == 0) ? longint'($urandom_range(0, DIST_MAX))
                              : longint'($urandom_range(0, int'(front_cap)));
        p.quality = 8'($urandom_range(4, 255));
      end else begin
        n_noise--;
        p.angle = 16'($urandom);
        d = $urandom_range(0, DIST_MAX);
        p.quality = 8'($urandom_range(0, 255));
      end
      p.distance = d[DIST_W-1:0];
      p.last_point = (remaining == 1);
      send_point(p);
      remaining--;
      random_points++;
    end
  endtask

  // main sequence
  initial begin
    reg_set_t s;
    int phase, budget;
    sb = new();
    random_points = 0;
    rst_ni <= 1'b0;
    quiet <= 1'b0;
    hold_req <= 1'b0;
    pnt.valid <= 1'b0;
    pnt.angle_q14 <= '0;
    pnt.distance_q2 <= '0;
    pnt.quality <= '0;
    pnt.last_point <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // field extremes and sector edges at reset settings, few side points
    send_fields(16'd0,     18'd0,      8'd0,   1'b0);
    send_fields(16'd65535, 18'd262143, 8'd255, 1'b0);
    send_fields(16'd9102,  18'd262143, 8'd3,   1'b0);
    send_fields(16'd9102,  18'd1000,   8'd4,   1'b0);
    send_fields(16'd16384, 18'd262143, 8'd255, 1'b0);
    send_fields(16'd9101,  18'd5,      8'd128, 1'b0);
    send_fields(16'd16385, 18'd7,      8'd64,  1'b0);
    send_fields(16'd1820,  18'd100,    8'd200, 1'b0);
    send_fields(16'd1821,  18'd100,    8'd200, 1'b0);
    send_fields(16'd63716, 18'd100,    8'd200, 1'b0);
    send_fields(16'd63715, 18'd1,      8'd255, 1'b0);
    send_fields(16'd32768, 18'd262143, 8'd255, 1'b1);
    // empty scan, then a scan whose only valid point is the last one
    send_fields(16'd0,     18'd262143, 8'd1,   1'b1);
    send_fields(16'd12000, 18'd4321,   8'd16,  1'b1);

    // a long scan at the largest distance on the side, zero distance in front
    for (int i = 0; i < FILL_POINTS; i++) begin
      send_fields(16'd12000, 18'd262143, 8'd255, 1'b0);
      send_fields(16'd0, 18'd0, 8'd255, (i == FILL_POINTS - 1));
    end
    finish_phase();

    // random phases, each with its own register setting
    phase = 0;
    while (random_points < RANDOM_POINTS) begin
      case (phase)
        0: s = '{gain_p: RST_GAIN_P, gain_i: RST_GAIN_I, gain_d: RST_GAIN_D,
                 setpoint: RST_SETPOINT, brake: RST_BRAKE, side_low: RST_SIDE_LOW,
                 side_high: RST_SIDE_HIGH, front_half: 16'(RST_FRONT_HALF)};
        1: s = '{gain_p: 16'hFFFF, gain_i: 16'hFFFF, gain_d: 16'hFFFF,
                 setpoint: 16'hFFFF, brake: 16'hFFFF, side_low: 16'd0,
                 side_high: 16'hFFFF, front_half: 16'd16384};
        2: s = '{gain_p: 16'd0, gain_i: 16'd0, gain_d: 16'd0,
                 setpoint: 16'd0, brake: 16'd0, side_low: 16'hFFFF,
                 side_high: 16'd0, front_half: 16'd0};
        default: begin
          s.gain_p = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
          s.gain_i = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
          s.gain_d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
          s.setpoint = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(100, 2000));
          s.brake = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(50, 1500));
          s.side_low = 16'($urandom);
          s.side_high = 16'($urandom);
          if (s.side_low > s.side_high && $urandom_range(0, 3) != 0) begin
            {s.side_low, s.side_high} = {s.side_high, s.side_low};
          end
          s.front_half = 16'($urandom_range(0, 16384));
        end
      endcase
      write_one(REG_GAIN_P, s.gain_p);
      write_one(REG_GAIN_I, s.gain_i);
      write_one(REG_GAIN_D, s.gain_d);
      write_one(REG_SETPOINT, s.setpoint);
      write_one(REG_BRAKE, s.brake);
      write_one(REG_SIDE_LOW, s.side_low);
      write_one(REG_SIDE_HIGH, s.side_high);
      write_one(REG_FRONT_HALF, s.front_half);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk);

      // first phase stalls the result side, a later one runs with no idling
      if (phase == 0) hold_req <= 1'b1;
      quiet <= (phase == 3);
      budget = random_points + PHASE_POINTS;
      while (random_points < budget) send_random_scan();
      finish_phase();
      phase++;
    end

    if (sb.failures == 0 && !sb.waiting()) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
